// File: src/tsf_pkg.sv
// Shared types and constants for the triangle span fill block.
package tsf_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

// File: src/tsf_div.sv
// Serial signed divider with truncating quotient, one quotient bit per cycle.
module tsf_div #(
    parameter int NUM_BITS = 28,
    parameter int DEN_BITS = 15
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [NUM_BITS-1:0] num,
    input  logic signed [DEN_BITS-1:0] den,
    output logic                       done,
    output logic signed [NUM_BITS-1:0] quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg, d_next;
    logic                neg_reg, neg_next;
    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = num[NUM_BITS-1] ? NUM_BITS'(-num) : num;
            d_next    = den[DEN_BITS-1] ? DEN_BITS'(-den) : den;
            neg_next  = num[NUM_BITS-1] ^ den[DEN_BITS-1];
            r_next    = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? NUM_BITS'(-q_reg) : q_reg;

endmodule

// File: src/tsf_front.sv
// Front end: sorts loaded vertices, walks rows and queues one job per span.
module tsf_front #(
    parameter int COORD_BITS = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output logic                         job_valid,
    input  logic                         job_ready,
    output logic [9*COORD_BITS:0]        job_data
);

    // Job: row, short start x/y, short end x/y, long start x/y, long end x/y, last.
    localparam int C = COORD_BITS;
    localparam int JW = 9 * C + 1;
    localparam int QD = 2;

    logic signed [C-1:0] vx_reg [3];
    logic signed [C-1:0] vy_reg [3];
    logic signed [C-1:0] row_reg;
    logic                active_reg;

    logic [JW-1:0] q_reg [QD];
    logic [1:0]    cnt_reg;
    logic          wp_reg, rp_reg;

    logic signed [C-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;
    logic signed [C-1:0] ox0, oy0, ox1, oy1, ox2, oy2;
    logic                last;
    logic                push, pop;
    logic [JW-1:0]       job;
    logic signed [C:0]   row_inc;

    assign in_ready = (cnt_reg != 2'd2);

    always_comb
    begin
        sx0 = ax; sy0 = ay; sx1 = bx; sy1 = by; sx2 = cx; sy2 = cy;
        tx = '0; ty = '0;
        if (sy0 > sy1)
        begin
            tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
        end
        if (sy1 > sy2)
        begin
            tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
        end
        if (sy0 > sy1)
        begin
            tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
        end
        ox0 = sx0; oy0 = sy0; ox1 = sx1; oy1 = sy1; ox2 = sx2; oy2 = sy2;
    end

    assign row_inc = {row_reg[C-1], row_reg} + (C+1)'(1);
    assign last    = row_inc >= $signed({vy_reg[2][C-1], vy_reg[2]});

    always_comb
    begin
        if (row_reg < vy_reg[1])
            job = {row_reg, vx_reg[0], vy_reg[0], vx_reg[1], vy_reg[1],
                   vx_reg[0], vy_reg[0], vx_reg[2], vy_reg[2], last};
        else
            job = {row_reg, vx_reg[1], vy_reg[1], vx_reg[2], vy_reg[2],
                   vx_reg[0], vy_reg[0], vx_reg[2], vy_reg[2], last};
    end

    assign push = in_valid && in_ready && (command == tsf_pkg::CMD_STEP) && active_reg;
    assign pop  = job_valid && job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
            row_reg    <= '0;
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            wp_reg     <= 1'b0;
            rp_reg     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (command == tsf_pkg::CMD_LOAD)
                begin
                    vx_reg[0] <= ox0; vy_reg[0] <= oy0;
                    vx_reg[1] <= ox1; vy_reg[1] <= oy1;
                    vx_reg[2] <= ox2; vy_reg[2] <= oy2;
                    row_reg    <= oy0;
                    active_reg <= oy0 < oy2;
                end
                else if (active_reg)
                begin
                    row_reg <= row_inc[C-1:0];
                    if (last)
                        active_reg <= 1'b0;
                end
            end
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= job;
    end

    assign job_valid = (cnt_reg != 2'd0);
    assign job_data  = q_reg[rp_reg];

endmodule

// File: src/tsf_back.sv
// Back end: evaluates both edge positions of a span with one shared divider.
module tsf_back #(
    parameter int COORD_BITS = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  logic [9*COORD_BITS:0]        job_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] row_y,
    output logic signed [COORD_BITS-1:0] span_from_x,
    output logic signed [COORD_BITS-1:0] span_to_x,
    output logic                         last_row
);

    localparam int C  = COORD_BITS;
    localparam int NB = 2 * C + 3;
    localparam int DB = C + 2;

    tsf_pkg::back_state_t state_reg, state_next;

    logic signed [C-1:0] row_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [C-1:0] lx0_reg, ly0_reg, lx1_reg, ly1_reg;
    logic                last_reg;
    logic                second_reg, second_next;
    logic signed [C-1:0] from_reg, to_reg;

    logic signed [C-1:0] s_x, s_y, e_x, e_y;
    logic signed [C:0]   dy_row, dx, h;
    logic signed [NB-1:0] prod_reg;
    logic signed [DB-1:0] den_reg;
    logic                start_reg, start_next;
    logic                mul_reg, mul_next;
    logic                drop_reg, drop_next;
    logic                div_done;
    logic signed [NB-1:0] quot;
    logic signed [C-1:0] res_x;
    logic                take;

    assign s_x = second_reg ? lx0_reg : ax_reg;
    assign s_y = second_reg ? ly0_reg : ay_reg;
    assign e_x = second_reg ? lx1_reg : bx_reg;
    assign e_y = second_reg ? ly1_reg : by_reg;
    assign dy_row = {row_reg[C-1], row_reg} - {s_y[C-1], s_y};
    assign dx     = {e_x[C-1], e_x} - {s_x[C-1], s_x};
    assign h      = {e_y[C-1], e_y} - {s_y[C-1], s_y};
    assign res_x  = C'(quot) + s_x;

    tsf_div #(.NUM_BITS(NB), .DEN_BITS(DB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .num   (prod_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    assign take      = (state_reg == tsf_pkg::BK_IDLE) && job_valid;
    assign job_ready = (state_reg == tsf_pkg::BK_IDLE);
    assign out_valid = (state_reg == tsf_pkg::BK_OUT);

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        start_next  = 1'b0;
        mul_next    = 1'b0;
        drop_next   = drop_reg;
        unique case (state_reg)
            tsf_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next  = tsf_pkg::BK_DIV;
                    second_next = 1'b0;
                    mul_next    = 1'b1;
                    drop_next   = 1'b0;
                end
            end
            tsf_pkg::BK_DIV:
            begin
                if (mul_reg)
                begin
                    if (h == '0)
                        drop_next = 1'b1;
                    start_next = 1'b1;
                end
                else if (div_done)
                begin
                    if (!second_reg)
                    begin
                        second_next = 1'b1;
                        mul_next    = 1'b1;
                    end
                    else if (drop_reg)
                        state_next = tsf_pkg::BK_IDLE;
                    else
                        state_next = tsf_pkg::BK_OUT;
                end
            end
            tsf_pkg::BK_OUT:
            begin
                if (out_ready)
                    state_next = tsf_pkg::BK_IDLE;
            end
            default:
                state_next = tsf_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tsf_pkg::BK_IDLE;
            second_reg <= 1'b0;
            start_reg  <= 1'b0;
            mul_reg    <= 1'b0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            start_reg  <= start_next;
            mul_reg    <= mul_next;
            drop_reg   <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            {row_reg, ax_reg, ay_reg, bx_reg, by_reg,
             lx0_reg, ly0_reg, lx1_reg, ly1_reg, last_reg} <= job_data;
        if (mul_reg)
        begin
            prod_reg <= NB'(dy_row * dx);
            // A zero height is replaced so the divider stays defined; the span is dropped.
            den_reg  <= (h == '0) ? DB'(1) : DB'(h);
        end
        if (div_done)
        begin
            if (second_reg)
                to_reg <= res_x;
            else
                from_reg <= res_x;
        end
    end

    assign row_y       = row_reg;
    assign span_from_x = from_reg;
    assign span_to_x   = to_reg;
    assign last_row    = last_reg;

endmodule

// File: src/triangle_span_fill_top.sv
// Top level of the triangle span fill block.
// Usage: the slave channel (s_tvalid/s_tready/s_tdata) takes command beats.
// A beat with command 0 loads three vertices; they are sorted by y and the
// row walk is set to the top row. A load produces no output beat.
// A beat with command 1 requests the next span. Each span comes out on the
// master channel as row_y, span_from_x and span_to_x in m_tdata, and the
// final span of the triangle carries m_tlast high. Steps with no triangle
// left produce nothing.
// The front end classifies each step and pushes a span job into a two-entry
// queue. The back end computes both edge crossings with one shared serial
// divider of 2*COORD_BITS+3 quotient bits, first the short edge and then the
// long edge, and takes a new span from the queue only after the previous one
// has left its output register or has been dropped.
// Reset clears the vertices, the row counter, the queue and the back end.
// When the receiver stalls, the finished span holds in the output register,
// the queue fills, and then s_tready drops until space frees up.
module triangle_span_fill_top #(
    parameter int COORD_BITS = 13
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // Fields from bit 0: command, ax, ay, bx, by, cx, cy, zero fill.
    input  logic [((6*COORD_BITS+1+7)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // Fields from bit 0: row_y, span_from_x, span_to_x, zero fill.
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_tdata,
    output logic                    m_tlast
);

    localparam int C   = COORD_BITS;
    localparam int OW  = ((3*C+7)/8)*8;

    logic                job_valid, job_ready;
    logic [9*C:0]        job_data;
    logic signed [C-1:0] row_y, span_from_x, span_to_x;

    tsf_front #(.COORD_BITS(C)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .command   (s_tdata[0]),
        .ax        (s_tdata[1 +: C]),
        .ay        (s_tdata[1+C +: C]),
        .bx        (s_tdata[1+2*C +: C]),
        .by        (s_tdata[1+3*C +: C]),
        .cx        (s_tdata[1+4*C +: C]),
        .cy        (s_tdata[1+5*C +: C]),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data)
    );

    tsf_back #(.COORD_BITS(C)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job_data    (job_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .row_y       (row_y),
        .span_from_x (span_from_x),
        .span_to_x   (span_to_x),
        .last_row    (m_tlast)
    );

    assign m_tdata = OW'({span_to_x, span_from_x, row_y});

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the triangle span fill block.
`timescale 1ns / 100ps

module tb_top;

    localparam int CB = 13;
    localparam int SW = ((6*CB+1+7)/8)*8;
    localparam int MW = ((3*CB+7)/8)*8;
    localparam int CYCLE_LIMIT = 400000;
    // Drain time after the last span, so the back end can finish its work.
    localparam int SETTLE_CYCLES = 200;
    localparam int MIN_C = -4096;
    localparam int MAX_C = 4095;

    typedef struct {
        logic signed [CB-1:0] row;
        logic signed [CB-1:0] from_x;
        logic signed [CB-1:0] to_x;
        logic                 last;
    } span_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [SW-1:0] s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [MW-1:0] m_tdata;
    logic          m_tlast;

    // Shadow state of the block.
    int  vert_x[3];
    int  vert_y[3];
    int  next_row;
    bit  walking;

    span_t pending_spans[$];
    int    items_sent;
    int    errors;
    int    cycles;
    bit    no_idle;

    triangle_span_fill_top #(.COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // The receiver stalls about 30 beats in a hundred unless a no-idle stretch is on.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= no_idle || ($urandom_range(99) >= 30);
    end

    // Swap when the upper entry's y is strictly greater, so ties keep input order.
    function automatic void order_vertices(int i, int j);
        int tx;
        int ty;
        if (vert_y[i] > vert_y[j])
        begin
            tx = vert_x[i];
            ty = vert_y[i];
            vert_x[i] = vert_x[j];
            vert_y[i] = vert_y[j];
            vert_x[j] = tx;
            vert_y[j] = ty;
        end
    endfunction

    // Edge crossing at row y from vertex s to vertex e; returns 0 on a zero height.
    function automatic bit edge_crossing(int s, int e, int y, output int x);
        int h;
        h = vert_y[e] - vert_y[s];
        x = 0;
        if (h == 0)
            return 1'b0;
        x = ((y - vert_y[s]) * (vert_x[e] - vert_x[s])) / h + vert_x[s];
        return 1'b1;
    endfunction

    // Advances the shadow state by one accepted beat and queues any span it produces.
    function automatic void predict_span(logic [SW-1:0] beat);
        logic signed [CB-1:0] c[6];
        int    y;
        int    fx;
        int    tx;
        bit    ok;
        bit    last;
        span_t sp;
        for (int k = 0; k < 6; k++)
            c[k] = beat[1+k*CB +: CB];
        if (beat[0] == tsf_pkg::CMD_LOAD)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vert_x[k] = c[2*k];
                vert_y[k] = c[2*k+1];
            end
            order_vertices(0, 1);
            order_vertices(1, 2);
            order_vertices(0, 1);
            next_row = vert_y[0];
            walking = vert_y[0] < vert_y[2];
            return;
        end
        if (!walking)
            return;
        y = next_row;
        last = (y + 1 >= vert_y[2]);
        next_row = y + 1;
        if (last)
            walking = 1'b0;
        if (y < vert_y[1])
            ok = edge_crossing(0, 1, y, fx);
        else
            ok = edge_crossing(1, 2, y, fx);
        if (!ok || !edge_crossing(0, 2, y, tx))
            return;
        sp.row = CB'(y);
        sp.from_x = CB'(fx);
        sp.to_x = CB'(tx);
        sp.last = last;
        pending_spans.push_back(sp);
    endfunction

    // Compares every accepted output beat with the oldest predicted span.
    always @(posedge clk)
    begin
        span_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_spans.size() == 0)
            begin
                $display("%0t: unexpected span beat, expected none, actual data %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = pending_spans.pop_front();
                if (m_tdata[CB-1:0] !== want.row)
                begin
                    $display("%0t: row_y expected %0d actual %0d", $time,
                             want.row, $signed(m_tdata[CB-1:0]));
                    errors++;
                end
                if (m_tdata[2*CB-1:CB] !== want.from_x)
                begin
                    $display("%0t: span_from_x expected %0d actual %0d", $time,
                             want.from_x, $signed(m_tdata[2*CB-1:CB]));
                    errors++;
                end
                if (m_tdata[3*CB-1:2*CB] !== want.to_x)
                begin
                    $display("%0t: span_to_x expected %0d actual %0d", $time,
                             want.to_x, $signed(m_tdata[3*CB-1:2*CB]));
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_row expected %b actual %b", $time,
                             want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Sends one command beat. The valid is lowered only when an idle gap follows,
    // so it never sees two nonblocking writes in one step.
    task automatic send_beat(input logic cmd, input int ax, input int ay, input int bx,
                             input int by, input int cx, input int cy);
        logic [SW-1:0] beat;
        logic signed [CB-1:0] f[6];
        f[0] = CB'(ax); f[1] = CB'(ay); f[2] = CB'(bx);
        f[3] = CB'(by); f[4] = CB'(cx); f[5] = CB'(cy);
        beat = '0;
        beat[0] = cmd;
        for (int k = 0; k < 6; k++)
            beat[1+k*CB +: CB] = f[k];
        if (!no_idle && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        predict_span(beat);
        items_sent++;
    endtask

    function automatic int rand_coord();
        return $urandom_range(MAX_C - MIN_C) + MIN_C;
    endfunction

    // A step beat carries random coordinate bits that the block must ignore.
    task automatic send_step();
        send_beat(tsf_pkg::CMD_STEP, rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic send_steps(input int n);
        for (int k = 0; k < n; k++)
            send_step();
    endtask

    // Waits until every predicted span has arrived, then lets the back end settle.
    task automatic drain_spans();
        s_tvalid <= 1'b0;
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_step_without_triangle();
        send_steps(3);
    endtask

    task automatic test_directed_shapes();
        // Extreme corners: a tall triangle cut short by the next load.
        send_beat(tsf_pkg::CMD_LOAD, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, MAX_C);
        send_steps(4);
        // Ties in y keep the input order of the vertices.
        send_beat(tsf_pkg::CMD_LOAD, 5, 10, -3, 10, 0, 14);
        send_steps(6);
        send_beat(tsf_pkg::CMD_LOAD, 0, 0, 7, 3, -2, 3);
        send_steps(4);
        // Flat triangle has no rows, so the following step is ignored.
        send_beat(tsf_pkg::CMD_LOAD, MIN_C, 7, MAX_C, 7, 0, 7);
        send_step();
        // Wide x spread makes the edges run across the block's full x range.
        send_beat(tsf_pkg::CMD_LOAD, MIN_C, MAX_C - 2, MAX_C, MAX_C - 1, MAX_C, MAX_C);
        send_steps(3);
        send_beat(tsf_pkg::CMD_LOAD, MAX_C, MIN_C, MIN_C, MIN_C + 1, MIN_C, MIN_C + 3);
        send_steps(4);
    endtask

    task automatic test_random_triangles(input int target);
        int top;
        int h;
        int mid;
        int sel;
        while (items_sent < target)
        begin
            sel = $urandom_range(99);
            if (sel < 85)
            begin
                h = $urandom_range(12);
                top = $urandom_range(MAX_C - 12 - MIN_C) + MIN_C;
                mid = top + $urandom_range(h);
                case ($urandom_range(2))
                    0: send_beat(tsf_pkg::CMD_LOAD, rand_coord(), top, rand_coord(), mid,
                                 rand_coord(), top + h);
                    1: send_beat(tsf_pkg::CMD_LOAD, rand_coord(), top + h, rand_coord(), top,
                                 rand_coord(), mid);
                    default: send_beat(tsf_pkg::CMD_LOAD, rand_coord(), mid, rand_coord(),
                                       top + h, rand_coord(), top);
                endcase
                send_steps(h + $urandom_range(2));
            end
            else if (sel < 93)
            begin
                // Full-range load abandoned after a few rows.
                send_beat(tsf_pkg::CMD_LOAD, rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord());
                send_steps($urandom_range(3));
            end
            else
                send_steps($urandom_range(1, 3));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        items_sent = 0;
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        walking = 1'b0;
        next_row = 0;
        for (int k = 0; k < 3; k++)
        begin
            vert_x[k] = 0;
            vert_y[k] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_step_without_triangle();
        test_directed_shapes();
        // The sender holds off here until every span so far has come out.
        drain_spans();
        test_random_triangles(200);
        no_idle = 1'b1;
        test_random_triangles(320);
        no_idle = 1'b0;
        test_random_triangles(440);
        drain_spans();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
